FILE: rtl/mmsor_pkg.sv
// Shared types, constants and tables of the membrane mirror SOR solver.
package mmsor_pkg;

	localparam int GRID_ROWS     = 64;
	localparam int GRID_COLS     = 64;
	localparam int MAX_ACTUATORS = 63;
	localparam int ROW_W         = $clog2(GRID_ROWS);
	localparam int COL_W         = $clog2(GRID_COLS);
	localparam int ADDR_W        = ROW_W + COL_W;
	localparam int VT_W          = $clog2(MAX_ACTUATORS);
	localparam int Q_W           = 40;
	localparam int SRC_W         = 27;
	localparam int SUM_W         = 56;

	localparam logic [1:0] MODE_VOLT = 2'd0;
	localparam logic [1:0] MODE_PIX  = 2'd1;
	localparam logic [1:0] MODE_RUN  = 2'd2;
	localparam logic [1:0] MODE_READ = 2'd3;

	localparam logic [2:0] CFG_GRID_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_GRID_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_RELAX       = 3'd2;
	localparam logic [2:0] CFG_ITER_LIMIT  = 3'd3;
	localparam logic [2:0] CFG_TOL_SHIFT   = 3'd4;

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_CLEAR  = 5'd1;
	localparam logic [4:0] ST_RUNCLR = 5'd2;
	localparam logic [4:0] ST_SWINIT = 5'd3;
	localparam logic [4:0] ST_P0     = 5'd4;
	localparam logic [4:0] ST_P1     = 5'd5;
	localparam logic [4:0] ST_P2     = 5'd6;
	localparam logic [4:0] ST_P3     = 5'd7;
	localparam logic [4:0] ST_P4     = 5'd8;
	localparam logic [4:0] ST_P5     = 5'd9;
	localparam logic [4:0] ST_P6     = 5'd10;
	localparam logic [4:0] ST_P7     = 5'd11;
	localparam logic [4:0] ST_P8     = 5'd12;
	localparam logic [4:0] ST_P9     = 5'd13;
	localparam logic [4:0] ST_CV0    = 5'd14;
	localparam logic [4:0] ST_CV1    = 5'd15;
	localparam logic [4:0] ST_CV2    = 5'd16;
	localparam logic [4:0] ST_CV3    = 5'd17;
	localparam logic [4:0] ST_CV4    = 5'd18;
	localparam logic [4:0] ST_CV5    = 5'd19;
	localparam logic [4:0] ST_CHECK  = 5'd20;
	localparam logic [4:0] ST_DONE   = 5'd21;

	typedef struct packed {
		logic [1:0] mode;
		logic [5:0] row;
		logic [5:0] col;
		logic       inside_req;
		logic [5:0] actuator;
		logic [7:0] voltage;
	} item_t;

	typedef struct packed {
		logic signed [39:0] deflection;
		logic [12:0]        iterations_done;
		logic               converged;
	} result_t;

	typedef struct packed {
		logic [6:0]  grid_width;
		logic [6:0]  grid_height;
		logic [16:0] relax_factor;
		logic [12:0] iteration_limit;
		logic [5:0]  tolerance_shift;
	} cfg_t;

	typedef struct packed {
		logic [4:0]        op;
		logic [ROW_W-1:0]  i;
		logic [COL_W-1:0]  j;
		logic [ADDR_W-1:0] clr_addr;
		logic              clr_pix;
		logic              item_wr;
		logic              item_rd;
	} cmd_t;

	typedef struct packed {
		logic              conv;
		logic signed [Q_W-1:0] rd_data;
	} stat_t;

	typedef logic [SRC_W-1:0] src_tab_t [256];

	function automatic src_tab_t src_tab_f();
		src_tab_t          t;
		longint unsigned   num;
		longint unsigned   den;
		logic [63:0]       rem;
		logic [63:0]       quo;
		den = 64'd65025 * 64'd757856;
		for (int v = 0; v < 256; v++) begin
			num = ((longint'(v) * longint'(v) * 64'd10000) << 32) + (den >> 1);
			rem = '0;
			quo = '0;
			// The rounded quotient comes from a shift and subtract long division.
			for (int b = 63; b >= 0; b--) begin
				rem = {rem[62:0], num[b]};
				if (rem >= den) begin
					rem = rem - den;
					quo[b] = 1'b1;
				end
			end
			t[v] = SRC_W'(quo);
		end
		return t;
	endfunction

	localparam src_tab_t SRC_TABLE = src_tab_f();

endpackage

FILE: rtl/mmsor_cfg.sv
// Configuration register file of the SOR solver.
module mmsor_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [16:0]         cfg_data,
	output mmsor_pkg::cfg_t     cfg
);

	mmsor_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width      <= 7'd64;
			cfg_q.grid_height     <= 7'd64;
			cfg_q.relax_factor    <= 17'd65536;
			cfg_q.iteration_limit <= 13'd16;
			cfg_q.tolerance_shift <= 6'd53;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mmsor_pkg::CFG_GRID_WIDTH:  cfg_q.grid_width      <= cfg_data[6:0];
				mmsor_pkg::CFG_GRID_HEIGHT: cfg_q.grid_height     <= cfg_data[6:0];
				mmsor_pkg::CFG_RELAX:       cfg_q.relax_factor    <= cfg_data;
				mmsor_pkg::CFG_ITER_LIMIT:  cfg_q.iteration_limit <= cfg_data[12:0];
				mmsor_pkg::CFG_TOL_SHIFT:   cfg_q.tolerance_shift <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/mmsor_ctrl.sv
// Controller state machine of the SOR solver: clearing, sweep order and run control.
module mmsor_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          mode,
	input  mmsor_pkg::cfg_t     cfg,
	input  mmsor_pkg::stat_t    stat,
	output mmsor_pkg::cmd_t     cmd,
	output logic                done,
	output logic                res_read,
	output logic [12:0]         iters,
	output logic                run_conv
);

	logic [4:0]                     state_q;
	logic [mmsor_pkg::ADDR_W-1:0]   clr_q;
	logic                           clr_pix_q;
	logic [mmsor_pkg::ROW_W-1:0]    i_q;
	logic [mmsor_pkg::COL_W-1:0]    j_q;
	logic [12:0]                    cnt_q;
	logic                           conv_q;
	logic                           rd_pend_q;
	logic                           accept;
	logic [6:0]                     rows;
	logic [6:0]                     cols;
	logic [mmsor_pkg::ROW_W-1:0]    last_i;
	logic [mmsor_pkg::COL_W-1:0]    last_j;
	logic                           interior;

	assign accept   = start && !busy;
	assign busy     = state_q != mmsor_pkg::ST_IDLE;
	assign rows     = (cfg.grid_width > 7'(mmsor_pkg::GRID_ROWS)) ?
			7'(mmsor_pkg::GRID_ROWS) : cfg.grid_width;
	assign cols     = (cfg.grid_height > 7'(mmsor_pkg::GRID_COLS)) ?
			7'(mmsor_pkg::GRID_COLS) : cfg.grid_height;
	assign interior = (rows >= 7'd3) && (cols >= 7'd3);
	assign last_i   = mmsor_pkg::ROW_W'(rows - 7'd2);
	assign last_j   = mmsor_pkg::COL_W'(cols - 7'd2);

	assign cmd.op       = state_q;
	assign cmd.i        = i_q;
	assign cmd.j        = j_q;
	assign cmd.clr_addr = clr_q;
	assign cmd.clr_pix  = clr_pix_q;
	assign cmd.item_wr  = accept && (mode == mmsor_pkg::MODE_VOLT || mode == mmsor_pkg::MODE_PIX);
	assign cmd.item_rd  = accept && (mode == mmsor_pkg::MODE_READ);

	assign done     = (state_q == mmsor_pkg::ST_DONE) || rd_pend_q;
	assign res_read = rd_pend_q;
	assign iters    = cnt_q;
	assign run_conv = conv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mmsor_pkg::ST_CLEAR;
			clr_q     <= '0;
			clr_pix_q <= 1'b1;
			i_q       <= '0;
			j_q       <= '0;
			cnt_q     <= '0;
			conv_q    <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= cmd.item_rd;
			unique case (state_q)
				mmsor_pkg::ST_IDLE: begin
					if (accept && mode == mmsor_pkg::MODE_RUN) begin
						state_q   <= mmsor_pkg::ST_RUNCLR;
						clr_q     <= '0;
						clr_pix_q <= 1'b0;
						cnt_q     <= '0;
						conv_q    <= 1'b0;
					end
				end
				mmsor_pkg::ST_CLEAR, mmsor_pkg::ST_RUNCLR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= (state_q == mmsor_pkg::ST_CLEAR) ?
								mmsor_pkg::ST_IDLE : mmsor_pkg::ST_SWINIT;
					end
				end
				mmsor_pkg::ST_SWINIT: begin
					i_q <= mmsor_pkg::ROW_W'(1);
					j_q <= mmsor_pkg::COL_W'(1);
					if (cnt_q >= cfg.iteration_limit) begin
						state_q <= mmsor_pkg::ST_DONE;
					end else if (interior) begin
						state_q <= mmsor_pkg::ST_P0;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= mmsor_pkg::ST_CV0;
					end
				end
				mmsor_pkg::ST_P9: begin
					if (j_q == last_j) begin
						j_q <= mmsor_pkg::COL_W'(1);
						if (i_q == last_i) begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= mmsor_pkg::ST_CV0;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= mmsor_pkg::ST_P0;
						end
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= mmsor_pkg::ST_P0;
					end
				end
				mmsor_pkg::ST_CHECK: begin
					if (stat.conv) begin
						conv_q  <= 1'b1;
						state_q <= mmsor_pkg::ST_DONE;
					end else begin
						state_q <= mmsor_pkg::ST_SWINIT;
					end
				end
				mmsor_pkg::ST_DONE: state_q <= mmsor_pkg::ST_IDLE;
				mmsor_pkg::ST_P0, mmsor_pkg::ST_P1, mmsor_pkg::ST_P2, mmsor_pkg::ST_P3,
				mmsor_pkg::ST_P4, mmsor_pkg::ST_P5, mmsor_pkg::ST_P6, mmsor_pkg::ST_P7,
				mmsor_pkg::ST_P8, mmsor_pkg::ST_CV0, mmsor_pkg::ST_CV1, mmsor_pkg::ST_CV2,
				mmsor_pkg::ST_CV3, mmsor_pkg::ST_CV4, mmsor_pkg::ST_CV5: begin
					state_q <= state_q + 5'd1;
				end
				default: state_q <= mmsor_pkg::ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/mmsor_dp.sv
// Datapath of the SOR solver: grid, pixel map and voltage memories and the relaxation arithmetic.
module mmsor_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  mmsor_pkg::item_t    item,
	input  mmsor_pkg::cfg_t     cfg,
	input  mmsor_pkg::cmd_t     cmd,
	output mmsor_pkg::stat_t    stat
);

	localparam int AW = mmsor_pkg::ADDR_W;
	localparam int QW = mmsor_pkg::Q_W;
	localparam logic signed [45:0] Q_MAX = 46'sd549755813887;
	localparam logic signed [45:0] Q_MIN = -46'sd549755813888;

	logic signed [QW-1:0] grid_mem [mmsor_pkg::GRID_ROWS*mmsor_pkg::GRID_COLS];
	logic [6:0]           pix_mem  [mmsor_pkg::GRID_ROWS*mmsor_pkg::GRID_COLS];
	logic [7:0]           vt_mem   [mmsor_pkg::MAX_ACTUATORS];
	logic [mmsor_pkg::MAX_ACTUATORS-1:0] vt_valid_q;

	logic signed [QW-1:0] rda_q, rdb_q, r_q;
	logic [6:0]           pm_rd_q;
	logic [7:0]           vt_rd_q;
	logic                 vok_q;
	logic signed [41:0]   ud_q, nb_q;
	logic [mmsor_pkg::SRC_W-1:0] src_q;
	logic signed [43:0]   d_q;
	logic [38:0]          plo_q;
	logic signed [39:0]   phi_q;
	logic signed [45:0]   c_q;
	logic [45:0]          ac_q;
	logic [63:0]          mul_q;
	logic signed [mmsor_pkg::SUM_W-1:0] sum_q;
	logic [63:0]          energy_q;
	logic [111:0]         acc_q;
	logic [63:0]          lo_q;
	logic                 hinz_q;
	logic                 conv_q;

	logic [AW-1:0]        addr_a, addr_b, addr_c, wr_addr;
	logic                 rd_a, rd_b, wr_en;
	logic signed [QW-1:0] wr_data;
	logic signed [63:0]   wsum;
	logic signed [45:0]   nr46;
	logic signed [QW-1:0] nr;
	logic [31:0]          ma, mb;
	logic [mmsor_pkg::SUM_W-1:0] sabs;
	logic [111:0]         acc_sh;
	logic [63:0]          sq;
	logic [64:0]          esum;
	logic [5:0]           act_pm;
	logic                 act_ok;
	logic                 vt_wr_ok;
	logic [mmsor_pkg::VT_W-1:0] vt_wr_idx, vt_rd_idx;

	assign addr_c = {cmd.i, cmd.j};
	assign wsum   = (64'(phi_q) <<< 22) + $signed({25'd0, plo_q}) + 64'sd131072;
	assign nr46   = 46'(r_q) + c_q;
	assign nr     = (nr46 > Q_MAX) ? QW'(Q_MAX) : ((nr46 < Q_MIN) ? QW'(Q_MIN) : QW'(nr46));
	assign sabs   = (sum_q < 0) ? mmsor_pkg::SUM_W'(-sum_q) : mmsor_pkg::SUM_W'(sum_q);
	assign acc_sh = acc_q >> cfg.tolerance_shift;
	assign sq     = (|ac_q[45:32]) ? '1 : mul_q;
	assign esum   = {1'b0, energy_q} + {1'b0, sq};
	assign act_pm = pm_rd_q[5:0];
	assign act_ok = (act_pm != 6'd0) && (7'(act_pm) <= 7'(mmsor_pkg::MAX_ACTUATORS));
	assign vt_rd_idx = mmsor_pkg::VT_W'(act_pm - 6'd1);
	assign vt_wr_ok  = cmd.item_wr && (item.mode == mmsor_pkg::MODE_VOLT) &&
			(item.actuator != 6'd0) &&
			(7'(item.actuator) <= 7'(mmsor_pkg::MAX_ACTUATORS));
	assign vt_wr_idx = mmsor_pkg::VT_W'(item.actuator - 6'd1);

	assign stat.conv    = conv_q;
	assign stat.rd_data = rda_q;

	always_comb begin
		addr_a  = addr_c;
		addr_b  = addr_c;
		rd_a    = 1'b0;
		rd_b    = 1'b0;
		wr_en   = 1'b0;
		wr_addr = addr_c;
		wr_data = '0;
		ma      = sabs[31:0];
		mb      = sabs[31:0];
		if (cmd.item_rd) begin
			addr_a = {item.row, item.col};
			rd_a   = 1'b1;
		end
		unique case (cmd.op)
			mmsor_pkg::ST_CLEAR, mmsor_pkg::ST_RUNCLR: begin
				wr_en   = 1'b1;
				wr_addr = cmd.clr_addr;
			end
			mmsor_pkg::ST_P0: begin
				addr_a = {cmd.i - 1'b1, cmd.j};
				addr_b = {cmd.i + 1'b1, cmd.j};
				rd_a   = 1'b1;
				rd_b   = 1'b1;
			end
			mmsor_pkg::ST_P1: begin
				addr_a = {cmd.i, cmd.j - 1'b1};
				addr_b = {cmd.i, cmd.j + 1'b1};
				rd_a   = 1'b1;
				rd_b   = 1'b1;
			end
			mmsor_pkg::ST_P2: rd_a = 1'b1;
			mmsor_pkg::ST_P7: begin
				wr_en   = 1'b1;
				wr_data = pm_rd_q[6] ? nr : '0;
			end
			mmsor_pkg::ST_P8: begin
				ma = ac_q[31:0];
				mb = ac_q[31:0];
			end
			mmsor_pkg::ST_CV1: ma = 32'(sabs[mmsor_pkg::SUM_W-1:32]);
			mmsor_pkg::ST_CV2: begin
				ma = 32'(sabs[mmsor_pkg::SUM_W-1:32]);
				mb = 32'(sabs[mmsor_pkg::SUM_W-1:32]);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			grid_mem[wr_addr] <= wr_data;
		end
		if (rd_a) begin
			rda_q <= grid_mem[addr_a];
		end
		if (rd_b) begin
			rdb_q <= grid_mem[addr_b];
		end
	end

	always_ff @(posedge clk) begin
		if ((cmd.op == mmsor_pkg::ST_CLEAR) && cmd.clr_pix) begin
			pix_mem[cmd.clr_addr] <= '0;
		end else if (cmd.item_wr && item.mode == mmsor_pkg::MODE_PIX) begin
			pix_mem[{item.row, item.col}] <= {item.inside_req, item.actuator};
		end
		if (cmd.op == mmsor_pkg::ST_P0) begin
			pm_rd_q <= pix_mem[addr_c];
		end
	end

	always_ff @(posedge clk) begin
		if (vt_wr_ok) begin
			vt_mem[vt_wr_idx] <= item.voltage;
		end
		if (cmd.op == mmsor_pkg::ST_P1) begin
			vt_rd_q <= vt_mem[vt_rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vt_valid_q <= '0;
		end else if (vt_wr_ok) begin
			vt_valid_q[vt_wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			energy_q <= '0;
			conv_q   <= 1'b0;
		end else begin
			unique case (cmd.op)
				mmsor_pkg::ST_SWINIT: begin
					sum_q    <= '0;
					energy_q <= '0;
				end
				mmsor_pkg::ST_P7: begin
					if (pm_rd_q[6]) begin
						sum_q <= sum_q + mmsor_pkg::SUM_W'(nr);
					end
				end
				mmsor_pkg::ST_P9: begin
					if (pm_rd_q[6]) begin
						energy_q <= esum[64] ? '1 : esum[63:0];
					end
				end
				mmsor_pkg::ST_CV5: begin
					conv_q <= (sum_q != 0) && (hinz_q || (energy_q <= lo_q));
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			mmsor_pkg::ST_P1: begin
				ud_q  <= 42'(rda_q) + 42'(rdb_q);
				vok_q <= act_ok && vt_valid_q[vt_rd_idx];
			end
			mmsor_pkg::ST_P2: begin
				nb_q  <= ud_q + 42'(rda_q) + 42'(rdb_q);
				src_q <= vok_q ? mmsor_pkg::SRC_TABLE[vt_rd_q] : '0;
			end
			mmsor_pkg::ST_P3: begin
				r_q <= rda_q;
				d_q <= 44'(nb_q) - $signed({17'd0, src_q}) - (44'(rda_q) <<< 2);
			end
			mmsor_pkg::ST_P4: plo_q <= {22'd0, cfg.relax_factor} * {17'd0, d_q[21:0]};
			mmsor_pkg::ST_P5: phi_q <= $signed({1'b0, cfg.relax_factor}) * $signed(d_q[43:22]);
			mmsor_pkg::ST_P6: c_q <= wsum[63:18];
			mmsor_pkg::ST_P7: ac_q <= (c_q < 0) ? 46'(-c_q) : 46'(c_q);
			mmsor_pkg::ST_P8, mmsor_pkg::ST_CV0: mul_q <= {32'd0, ma} * {32'd0, mb};
			mmsor_pkg::ST_CV1: begin
				acc_q <= {48'd0, mul_q};
				mul_q <= {32'd0, ma} * {32'd0, mb};
			end
			mmsor_pkg::ST_CV2: begin
				acc_q <= acc_q + {15'd0, mul_q, 33'd0};
				mul_q <= {32'd0, ma} * {32'd0, mb};
			end
			mmsor_pkg::ST_CV3: acc_q <= acc_q + {mul_q[47:0], 64'd0};
			mmsor_pkg::ST_CV4: begin
				lo_q   <= acc_sh[63:0];
				hinz_q <= |acc_sh[111:64];
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/membrane_mirror_sor_solver_core.sv
// Top level of the membrane mirror SOR solver core.
// Voltage and pixel loads give no result; a read gives its beat
// on done in the cycle after it is taken, and the next item may follow at once.
// A run clears the grid, then sweeps, updating every interior pixel in turn and
// checking for convergence after each sweep; done pulses when it ends.
// After reset the pixel map and grid are cleared with busy high.
// The receiver cannot stall: each result beat is valid for exactly one cycle.
module membrane_mirror_sor_solver_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mmsor_pkg::item_t    item,
	output logic                done,
	output mmsor_pkg::result_t  result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [16:0]         cfg_data
);

	mmsor_pkg::cfg_t  cfg;
	mmsor_pkg::cmd_t  cmd;
	mmsor_pkg::stat_t stat;
	logic             res_read;
	logic [12:0]      iters;
	logic             run_conv;

	mmsor_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mmsor_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.mode     (item.mode),
		.cfg      (cfg),
		.stat     (stat),
		.cmd      (cmd),
		.done     (done),
		.res_read (res_read),
		.iters    (iters),
		.run_conv (run_conv)
	);

	mmsor_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg),
		.cmd    (cmd),
		.stat   (stat)
	);

	assign result.deflection      = res_read ? stat.rd_data : '0;
	assign result.iterations_done = res_read ? '0 : iters;
	assign result.converged       = res_read ? 1'b0 : run_conv;

endmodule

FILE: tb/mmsor_checker.sv
// Checker for the membrane mirror SOR solver: tracks settings, predicts every result and compares.
module mmsor_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  mmsor_pkg::item_t   item,
	input  logic               done,
	input  mmsor_pkg::result_t result,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [16:0]        cfg_data,
	output int                 pending,
	output int                 errors
);
	import mmsor_pkg::*;

	localparam longint Q_HI = 64'sd549755813887;
	localparam longint Q_LO = -64'sd549755813888;

	cfg_t                    settings;
	longint                  deflection_grid [GRID_ROWS*GRID_COLS];
	logic [6:0]              pixel_map [GRID_ROWS*GRID_COLS];
	logic [7:0]              drive_levels [MAX_ACTUATORS];
	result_t                 expected_results [$];

	assign pending = expected_results.size();

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		if (errors <= 30)
			$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
	endtask

	function automatic longint source_term(logic [7:0] v);
		longint unsigned num;
		longint unsigned den;
		num = (longint'(v) * longint'(v) * 64'd10000) << 32;
		den = 64'd65025 * 64'd757856;
		return longint'((num + den / 2) / den);
	endfunction

	function automatic bit energy_within(longint unsigned e, longint s, logic [5:0] sh);
		longint unsigned a;
		logic [127:0]    sq;
		a = (s < 0) ? -s : s;
		sq = {64'd0, a} * {64'd0, a};
		sq = sq >> sh;
		return (sq[127:64] != 0) || (e <= sq[63:0]);
	endfunction

	// Runs the whole relaxation and returns the run's result beat.
	function automatic result_t solve_membrane();
		result_t         res;
		int              rows;
		int              cols;
		int              k;
		int              sweeps;
		bit              conv;
		longint          w;
		longint          src;
		longint          r;
		longint          d;
		longint          c;
		longint          nr;
		longint          total;
		longint unsigned energy;
		longint unsigned ac;
		longint unsigned sq;
		rows = (settings.grid_width < GRID_ROWS) ? settings.grid_width : GRID_ROWS;
		cols = (settings.grid_height < GRID_COLS) ? settings.grid_height : GRID_COLS;
		w = settings.relax_factor;
		foreach (deflection_grid[n])
			deflection_grid[n] = 0;
		sweeps = 0;
		conv = 0;
		while (sweeps < settings.iteration_limit && !conv) begin
			total = 0;
			energy = 0;
			for (int i = 1; i + 1 < rows; i++) begin
				for (int j = 1; j + 1 < cols; j++) begin
					k = i * GRID_COLS + j;
					if (!pixel_map[k][6]) begin
						deflection_grid[k] = 0;
						continue;
					end
					src = 0;
					if (pixel_map[k][5:0] >= 1 && pixel_map[k][5:0] <= MAX_ACTUATORS)
						src = source_term(drive_levels[pixel_map[k][5:0] - 1]);
					r = deflection_grid[k];
					d = deflection_grid[k - GRID_COLS] + deflection_grid[k + GRID_COLS]
						+ deflection_grid[k - 1] + deflection_grid[k + 1] - src - 4 * r;
					c = (w * d + (64'sd1 << 17)) >>> 18;
					nr = r + c;
					if (nr > Q_HI)
						nr = Q_HI;
					if (nr < Q_LO)
						nr = Q_LO;
					deflection_grid[k] = nr;
					total += nr;
					ac = (c < 0) ? -c : c;
					sq = (ac >= 64'h1_0000_0000) ? '1 : ac * ac;
					energy = ('1 - energy < sq) ? '1 : energy + sq;
				end
			end
			sweeps++;
			if (total != 0 && energy_within(energy, total, settings.tolerance_shift))
				conv = 1;
		end
		res.deflection = '0;
		res.iterations_done = sweeps[12:0];
		res.converged = conv;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t beat;
		if (!arst_n) begin
			settings <= '{grid_width: 7'd64, grid_height: 7'd64, relax_factor: 17'd65536,
				iteration_limit: 13'd16, tolerance_shift: 6'd53};
			foreach (pixel_map[n])
				pixel_map[n] = '0;
			foreach (deflection_grid[n])
				deflection_grid[n] = 0;
			foreach (drive_levels[n])
				drive_levels[n] = '0;
			errors = 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result beat", 1, 0);
				end else begin
					want = expected_results.pop_front();
					if (result.deflection !== want.deflection)
						report_mismatch("deflection", result.deflection, want.deflection);
					if (result.iterations_done !== want.iterations_done)
						report_mismatch("iterations_done", result.iterations_done,
							want.iterations_done);
					if (result.converged !== want.converged)
						report_mismatch("converged", result.converged, want.converged);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_GRID_WIDTH: settings.grid_width <= cfg_data[6:0];
					CFG_GRID_HEIGHT: settings.grid_height <= cfg_data[6:0];
					CFG_RELAX: settings.relax_factor <= cfg_data;
					CFG_ITER_LIMIT: settings.iteration_limit <= cfg_data[12:0];
					CFG_TOL_SHIFT: settings.tolerance_shift <= cfg_data[5:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				case (item.mode)
					MODE_VOLT: begin
						if (item.actuator >= 1 && item.actuator <= MAX_ACTUATORS)
							drive_levels[item.actuator - 1] = item.voltage;
					end
					MODE_PIX: begin
						pixel_map[{item.row, item.col}] = {item.inside_req, item.actuator};
					end
					MODE_RUN: begin
						expected_results.push_back(solve_membrane());
					end
					default: begin
						beat = '0;
						beat.deflection = deflection_grid[{item.row, item.col}][39:0];
						expected_results.push_back(beat);
					end
				endcase
			end
		end
	end

	final begin
		if (expected_results.size() != 0)
			$display("results still outstanding: %0d", expected_results.size());
	end
endmodule

FILE: tb/membrane_mirror_sor_solver_core_tb.sv
// Testbench top for the membrane mirror SOR solver core: stimulus, settings phases and verdict.
module membrane_mirror_sor_solver_core_tb;
	import mmsor_pkg::*;

	localparam int STALL_LIMIT = 300000;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	item_t     item;
	logic      done;
	result_t   result;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [2:0]  cfg_index;
	logic [16:0] cfg_data;
	int        pending;
	int        errors;
	int        quiet_cycles;
	int        idle_pct;
	int        rows_used;
	int        cols_used;

	membrane_mirror_sor_solver_core i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	mmsor_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .pending(pending), .errors(errors)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("membrane_mirror_sor_solver_core_tb: FAIL");
			$finish;
		end
	end

	task automatic send_item(logic [1:0] m, int r, int c, bit ins, int act, int v);
		int gap;
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= '{mode: m, row: r[5:0], col: c[5:0], inside_req: ins,
			actuator: act[5:0], voltage: v[7:0]};
		do @(posedge clk); while (busy);
	endtask

	// Waits until the block has drained before touching the settings.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_setting(logic [2:0] idx, int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[16:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(int gw, int gh, int relax, int iters, int tol);
		drain();
		write_setting(CFG_GRID_WIDTH, gw);
		write_setting(CFG_GRID_HEIGHT, gh);
		write_setting(CFG_RELAX, relax);
		write_setting(CFG_ITER_LIMIT, iters);
		write_setting(CFG_TOL_SHIFT, tol);
		rows_used = (gw < 3 || gw > 64) ? 64 : gw;
		cols_used = (gh < 3 || gh > 64) ? 64 : gh;
	endtask

	task automatic random_item();
		int pick;
		int r;
		int c;
		pick = $urandom_range(99);
		if ($urandom_range(9) < 8) begin
			r = $urandom_range(rows_used - 1);
			c = $urandom_range(cols_used - 1);
		end else begin
			r = $urandom_range(63);
			c = $urandom_range(63);
		end
		if (pick < 25)
			send_item(MODE_VOLT, $urandom_range(63), $urandom_range(63), $urandom_range(1),
				$urandom_range(63), $urandom_range(255));
		else if (pick < 60)
			send_item(MODE_PIX, r, c, ($urandom_range(9) < 8), $urandom_range(63),
				$urandom_range(255));
		else if (pick < 95)
			send_item(MODE_READ, r, c, $urandom_range(1), $urandom_range(63),
				$urandom_range(255));
		else
			send_item(MODE_RUN, r, c, $urandom_range(1), $urandom_range(63),
				$urandom_range(255));
	endtask

	task automatic read_all();
		for (int r = 0; r < rows_used && r < 4; r++)
			for (int c = 0; c < cols_used && c < 4; c++)
				send_item(MODE_READ, r, c, 0, 0, 0);
	endtask

	initial begin
		int idles [3];
		int relax;
		idles = '{0, 75, 13};
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet_cycles = 0;
		idle_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		apply_settings(6, 6, 98304, 8, 20);
		write_setting(3'd5, 17'h1FFFF);
		write_setting(3'd7, 0);
		send_item(MODE_VOLT, 0, 0, 0, 1, 255);
		send_item(MODE_VOLT, 63, 63, 1, 63, 0);
		send_item(MODE_VOLT, 0, 0, 0, 0, 200);
		send_item(MODE_VOLT, 0, 0, 0, 2, 128);
		send_item(MODE_PIX, 2, 2, 1, 1, 0);
		send_item(MODE_PIX, 2, 3, 1, 2, 255);
		send_item(MODE_PIX, 3, 2, 1, 0, 0);
		send_item(MODE_PIX, 3, 3, 1, 63, 0);
		send_item(MODE_PIX, 1, 1, 0, 1, 0);
		send_item(MODE_PIX, 4, 4, 1, 1, 0);
		send_item(MODE_PIX, 0, 0, 1, 1, 0);
		send_item(MODE_PIX, 63, 63, 1, 63, 255);
		send_item(MODE_RUN, 0, 0, 0, 0, 0);
		send_item(MODE_READ, 2, 2, 0, 0, 0);
		send_item(MODE_READ, 3, 3, 0, 0, 0);
		send_item(MODE_READ, 0, 0, 0, 0, 0);
		send_item(MODE_READ, 1, 1, 0, 0, 0);
		send_item(MODE_READ, 63, 63, 1, 63, 255);

		apply_settings(3, 3, 131071, 4096, 63);
		send_item(MODE_PIX, 1, 1, 1, 1, 0);
		send_item(MODE_RUN, 0, 0, 0, 0, 0);
		send_item(MODE_READ, 1, 1, 0, 0, 0);
		apply_settings(3, 3, 70000, 2047, 0);
		send_item(MODE_RUN, 0, 0, 0, 0, 0);
		send_item(MODE_READ, 1, 1, 0, 0, 0);
		apply_settings(64, 127, 65536, 1, 0);
		send_item(MODE_RUN, 0, 0, 0, 0, 0);
		send_item(MODE_READ, 2, 2, 0, 0, 0);
		apply_settings(0, 5, 0, 0, 10);
		send_item(MODE_RUN, 0, 0, 0, 0, 0);
		apply_settings(5, 5, 0, 3, 10);
		send_item(MODE_RUN, 0, 0, 0, 0, 0);
		send_item(MODE_READ, 2, 2, 0, 0, 0);

		for (int ph = 0; ph < 10; ph++) begin
			relax = ($urandom_range(9) == 0) ? $urandom_range(131071)
				: $urandom_range(65536, 131071);
			idle_pct = 0;
			apply_settings($urandom_range(3, 10), $urandom_range(3, 10), relax,
				$urandom_range(1, 24), $urandom_range(63));
			idle_pct = idles[ph % 3];
			for (int n = 0; n < 20; n++)
				random_item();
			send_item(MODE_RUN, 0, 0, 0, 0, 0);
			read_all();
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("membrane_mirror_sor_solver_core_tb: PASS");
		else
			$display("membrane_mirror_sor_solver_core_tb: FAIL");
		$finish;
	end
endmodule
